### hdl/bfs_pkg.sv
`default_nettype none

package bfs_pkg;

  // Default sizing of the set.
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_FLAG_WIDTH = 32;

  // Fixed widths of the transfer fields.
  localparam int VALUE_WIDTH     = 32;
  localparam int COUNT_OUT_WIDTH = 7;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } bfs_func_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } bfs_state_t;

  typedef struct packed {
    bfs_func_t                func;
    logic signed [VALUE_WIDTH-1:0] flag_value;
  } bfs_req_t;

  typedef struct packed {
    logic                       was_present;
    logic                       overflow_error;
    logic [COUNT_OUT_WIDTH-1:0] count_after;
  } bfs_rsp_t;

endpackage

`default_nettype wire

### hdl/bounded_flag_set_core.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   bfs_req_t (func, flag_value)
// rsp       out        rsp_valid/rsp_ready   bfs_rsp_t (was_present, overflow_error, count_after)
//
// One request is handled at a time; the scan reads one stored entry per cycle and stops at a
// hit, a miss scans every held entry, and a remove that hits then shifts the later entries
// down by one place. A clear empties the set without a scan.
// Reset empties the set at once; the memory contents are not cleared.
// A stalled response waits in its output register while the next request is processed.

module bounded_flag_set_core
  import bfs_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int FLAG_WIDTH = DEF_FLAG_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire bfs_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output bfs_rsp_t      rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  bfs_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic rd_pend, rd_pend_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  bfs_func_t op, op_next;
  logic [FLAG_WIDTH-1:0] key, key_next;
  logic found, found_next;
  logic ovf, ovf_next;
  bfs_rsp_t rsp_next;
  logic rsp_valid_next;
  logic rsp_load;

  // Entry memory ports.
  logic [FLAG_WIDTH-1:0] mem [CAPACITY];
  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [FLAG_WIDTH-1:0] rd_data;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [FLAG_WIDTH-1:0] wr_data;
  logic hit;

  assign req_ready = (state == ST_IDLE);
  assign hit = rd_pend && (rd_data == key);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_pend   <= rd_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    rd_idx   <= rd_idx_next;
    op       <= op_next;
    key      <= key_next;
    found    <= found_next;
    ovf      <= ovf_next;
    rsp      <= rsp_next;
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer: next state, memory control and response.
  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    rd_pend_next   = 1'b0;
    rd_idx_next    = rd_idx;
    op_next        = op;
    key_next       = key;
    found_next     = found;
    ovf_next       = ovf;
    rd_en          = 1'b0;
    rd_addr        = scan_idx[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = count[IDX_W-1:0];
    wr_data        = key;
    rsp_load       = 1'b0;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_next       = req.func;
          key_next      = FLAG_WIDTH'($unsigned(req.flag_value));
          found_next    = 1'b0;
          ovf_next      = 1'b0;
          scan_idx_next = '0;
          if (req.func == FUNC_CLEAR) begin
            count_next = '0;
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read unless the entry just read matched.
        if (!hit && (scan_idx < count)) begin
          rd_en         = 1'b1;
          rd_pend_next  = 1'b1;
          rd_idx_next   = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + CNT_W'(1);
        end
        if (hit) begin
          found_next = 1'b1;
          if (op == FUNC_REMOVE) begin
            scan_idx_next = CNT_W'(rd_idx) + CNT_W'(1);
            state_next    = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end else if (!rd_pend && (scan_idx >= count)) begin
          // Value absent: an insert appends it or reports a full set.
          if (op == FUNC_INSERT) begin
            if (count >= CNT_W'(CAPACITY)) begin
              ovf_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end
          state_next = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // Move each later entry down by one place, read and write overlapped.
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - IDX_W'(1);
          wr_data = rd_data;
        end
        if (scan_idx < count) begin
          rd_en         = 1'b1;
          rd_pend_next  = 1'b1;
          rd_idx_next   = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + CNT_W'(1);
        end else if (!rd_pend) begin
          count_next = count - CNT_W'(1);
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!rsp_valid || rsp_ready) begin
          rsp_load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (rsp_load) begin
      rsp_next.was_present    = found;
      rsp_next.overflow_error = ovf;
      rsp_next.count_after    = COUNT_OUT_WIDTH'(count);
    end
  end

  // The number of held entries never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A clear empties the set in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.func == FUNC_CLEAR) |=> (count == '0))
    else $error("clear did not empty the set");

  // Writes only land inside the list or at its end.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= count) && (CNT_W'(wr_addr) < CNT_W'(CAPACITY)))
    else $error("entry write outside the held list");

  // An overflow is only reported for a value that was absent.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.overflow_error) |-> !rsp.was_present)
    else $error("overflow reported for a present value");

endmodule

`default_nettype wire
